[sv/mpm_pkg.sv]
package mpm_pkg;

  // Field widths
  localparam int unsigned ENTRY_W = 20;
  localparam int unsigned POWER_W = 63;
  localparam int unsigned DEF_EXP_BITS = 63;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 144;
  localparam int unsigned OUT_DATA_W = 80;

  // Modulus and the Barrett constants for sums below 2^41
  localparam logic [ENTRY_W-1:0] MODULUS = 20'd1000007;
  localparam int unsigned OPND_W   = 22;  // multiplier operand width
  localparam int unsigned PROD_W   = 2 * OPND_W;
  localparam int unsigned SUM_W    = 41;  // a*b + c*d with all terms below MODULUS
  localparam int unsigned REM_W    = 22;  // holds a remainder below 3 * MODULUS
  localparam int unsigned SUM_SHIFT = SUM_W - OPND_W;    // x >> 19 keeps 22 bits
  localparam int unsigned QUO_SHIFT = PROD_W - OPND_W;   // (t * R) >> 22
  // floor(2^41 / MODULUS)
  localparam logic [OPND_W-1:0] BARRETT_R = 22'd2199007;

  // 2x2 matrix, row one column one in the lowest bits
  typedef struct packed {
    logic [ENTRY_W-1:0] r2c2;
    logic [ENTRY_W-1:0] r2c1;
    logic [ENTRY_W-1:0] r1c2;
    logic [ENTRY_W-1:0] r1c1;
  } mat_t;

  localparam mat_t IDENTITY = '{r2c2: 20'd1, r2c1: 20'd0, r1c2: 20'd0, r1c1: 20'd1};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_LAUNCH,
    ST_MUL,
    ST_OUT
  } mpm_state_e;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL1,
    U_MUL2,
    U_SUM,
    U_QEST,
    U_QM,
    U_DIFF,
    U_FIX
  } mpm_unit_state_e;

endpackage

[sv/mpm_mulmod.sv]
// Shared multiply-reduce unit: (a*b + c*d) mod MODULUS on one 22x22 multiplier.
module mpm_mulmod
  import mpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [ENTRY_W-1:0] opnd_a_i,
  input  logic [ENTRY_W-1:0] opnd_b_i,
  input  logic [ENTRY_W-1:0] opnd_c_i,
  input  logic [ENTRY_W-1:0] opnd_d_i,
  output logic               done_o,
  output logic [ENTRY_W-1:0] result_o
);

  mpm_unit_state_e state_q, state_d;

  logic [OPND_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [REM_W-1:0]  rem_q, rem_d;

  assign prod_d = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    rem_d   = rem_q;
    mul_a   = '0;
    mul_b   = '0;
    done_o  = 1'b0;
    unique case (state_q)
      U_IDLE: begin
        if (start_i) state_d = U_MUL1;
      end
      U_MUL1: begin
        mul_a   = OPND_W'(opnd_a_i);
        mul_b   = OPND_W'(opnd_b_i);
        state_d = U_MUL2;
      end
      U_MUL2: begin
        mul_a   = OPND_W'(opnd_c_i);
        mul_b   = OPND_W'(opnd_d_i);
        sum_d   = prod_q[SUM_W-1:0];
        state_d = U_SUM;
      end
      U_SUM: begin
        sum_d   = sum_q + prod_q[SUM_W-1:0];
        state_d = U_QEST;
      end
      U_QEST: begin
        // quotient estimate, at most two below the true quotient
        mul_a   = sum_q[SUM_W-1:SUM_SHIFT];
        mul_b   = BARRETT_R;
        state_d = U_QM;
      end
      U_QM: begin
        mul_a   = prod_q[PROD_W-1:QUO_SHIFT];
        mul_b   = OPND_W'(MODULUS);
        state_d = U_DIFF;
      end
      U_DIFF: begin
        // remainder stays below 2^22, so the low bits suffice
        rem_d   = sum_q[REM_W-1:0] - prod_q[REM_W-1:0];
        state_d = U_FIX;
      end
      U_FIX: begin
        if (rem_q >= REM_W'(MODULUS)) begin
          rem_d = rem_q - REM_W'(MODULUS);
        end else begin
          done_o  = 1'b1;
          state_d = U_IDLE;
        end
      end
      default: state_d = U_IDLE;
    endcase
  end

  assign result_o = rem_q[ENTRY_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
    rem_q  <= rem_d;
  end

endmodule

[sv/matrix_power_mod.sv]
// A zero exponent needs no matrix products; otherwise P = popcount(power) +
// bitlength(power) - 1 matrix products are formed. One request at a time; the
// next is taken once the result sits in the output register. Rate is set by
// the single shared multiply-reduce unit. Reset (rst_ni low, async) clears
// control state.
module matrix_power_mod
  import mpm_pkg::*;
#(
  parameter int unsigned EXP_BITS = DEF_EXP_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [19:0] entry_r1c1, [39:20] entry_r1c2, [59:40] entry_r2c1,
  // [79:60] entry_r2c2, [142:80] power, [143] zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [19:0] result_r1c1, [39:20] result_r1c2, [59:40] result_r2c1,
  // [79:60] result_r2c2
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // Entries arrive below 2^20 < 2 * MODULUS, so one subtract reduces them.
  function automatic logic [ENTRY_W-1:0] reduce_entry(input logic [ENTRY_W-1:0] e);
    reduce_entry = (e >= MODULUS) ? e - MODULUS : e;
  endfunction

  mpm_state_e state_q, state_d;

  logic [1:0]          ent_q, ent_d;      // entry of the product being formed
  logic                op_sq_q, op_sq_d;  // high: square the base, low: acc * base
  logic [EXP_BITS-1:0] exp_q, exp_d;      // exponent bits still to consume
  mat_t                acc_q, acc_d;
  mat_t                base_q, base_d;
  mat_t                new_q, new_d;      // product entries under construction
  mat_t                out_q, out_d;
  logic                m_valid_q, m_valid_d;

  logic               unit_start, unit_done;
  logic [ENTRY_W-1:0] unit_result;
  logic [ENTRY_W-1:0] opnd_a, opnd_b, opnd_c, opnd_d;
  mat_t               lhs_mat, done_mat, in_mat;
  logic [63:0]        power_ext;

  // Unpack the request
  assign in_mat.r1c1 = reduce_entry(s_axis_tdata[19:0]);
  assign in_mat.r1c2 = reduce_entry(s_axis_tdata[39:20]);
  assign in_mat.r2c1 = reduce_entry(s_axis_tdata[59:40]);
  assign in_mat.r2c2 = reduce_entry(s_axis_tdata[79:60]);
  assign power_ext   = 64'(s_axis_tdata[80 +: POWER_W]);

  // Operand selection: entry (i, j) of lhs * base is lhs[i,1]*base[1,j] + lhs[i,2]*base[2,j]
  assign lhs_mat = op_sq_q ? base_q : acc_q;

  always_comb begin
    unique case (ent_q)
      2'd0: begin
        opnd_a = lhs_mat.r1c1; opnd_b = base_q.r1c1;
        opnd_c = lhs_mat.r1c2; opnd_d = base_q.r2c1;
      end
      2'd1: begin
        opnd_a = lhs_mat.r1c1; opnd_b = base_q.r1c2;
        opnd_c = lhs_mat.r1c2; opnd_d = base_q.r2c2;
      end
      2'd2: begin
        opnd_a = lhs_mat.r2c1; opnd_b = base_q.r1c1;
        opnd_c = lhs_mat.r2c2; opnd_d = base_q.r2c1;
      end
      2'd3: begin
        opnd_a = lhs_mat.r2c1; opnd_b = base_q.r1c2;
        opnd_c = lhs_mat.r2c2; opnd_d = base_q.r2c2;
      end
      default: begin
        opnd_a = '0; opnd_b = '0; opnd_c = '0; opnd_d = '0;
      end
    endcase
  end

  mpm_mulmod u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (unit_start),
    .opnd_a_i (opnd_a),
    .opnd_b_i (opnd_b),
    .opnd_c_i (opnd_c),
    .opnd_d_i (opnd_d),
    .done_o   (unit_done),
    .result_o (unit_result)
  );

  // The last entry comes straight from the unit
  always_comb begin
    done_mat      = new_q;
    done_mat.r2c2 = unit_result;
  end

  // Sequencer: scan the exponent from its low bit. A set low bit multiplies
  // the accumulator by the base and clears the bit; a clear low bit with
  // higher bits left squares the base and shifts. Stop once nothing is left.
  always_comb begin
    state_d       = state_q;
    ent_d         = ent_q;
    op_sq_d       = op_sq_q;
    exp_d         = exp_q;
    acc_d         = acc_q;
    base_d        = base_q;
    new_d         = new_q;
    out_d         = out_q;
    m_valid_d     = m_valid_q & ~m_axis_tready;
    s_axis_tready = 1'b0;
    unit_start    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          base_d  = in_mat;
          acc_d   = IDENTITY;
          exp_d   = power_ext[EXP_BITS-1:0];
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (exp_q == '0) begin
          state_d = ST_OUT;
        end else begin
          op_sq_d = ~exp_q[0];
          ent_d   = '0;
          state_d = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        unit_start = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        if (unit_done) begin
          unique case (ent_q)
            2'd0: new_d.r1c1 = unit_result;
            2'd1: new_d.r1c2 = unit_result;
            2'd2: new_d.r2c1 = unit_result;
            2'd3: new_d.r2c2 = unit_result;
            default: new_d = new_q;
          endcase
          if (ent_q == 2'd3) begin
            // commit the finished product
            if (op_sq_q) begin
              base_d = done_mat;
              exp_d  = exp_q >> 1;
            end else begin
              acc_d    = done_mat;
              exp_d[0] = 1'b0;
            end
            state_d = ST_STEP;
          end else begin
            ent_d   = ent_q + 2'd1;
            state_d = ST_LAUNCH;
          end
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          out_d     = acc_q;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      ent_q     <= '0;
      op_sq_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      ent_q     <= ent_d;
      op_sq_q   <= op_sq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q  <= exp_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    new_q  <= new_d;
    out_q  <= out_d;
  end

endmodule
